@@ src/swept_path_collision_check_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SWEPT_PATH_COLLISION_CHECK_DEFINES_SVH
`define SWEPT_PATH_COLLISION_CHECK_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SPCC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("spcc: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define SPCC_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("spcc: same-cycle property failed");

`endif

@@ src/spcc_pkg.sv @@
package spcc_pkg;

	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = 32;

	localparam logic signed [63:0] SAT_LIM = 64'sd2147483647;
	localparam logic [63:0] U_CAP = 64'd1 << 50;

	typedef enum logic [2:0] {
		CFG_OWN_INDEX   = 3'd0,
		CFG_DRONE_COUNT = 3'd1,
		CFG_CLEARANCE   = 3'd2,
		CFG_SEG_TOL     = 3'd3,
		CFG_MIN_SPEED   = 3'd4
	} cfg_reg_t;

	function automatic logic signed [31:0] sat_val(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > SAT_LIM) begin
			r = SAT_LIM[31:0];
		end else if (x < -SAT_LIM) begin
			r = -SAT_LIM[31:0];
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

@@ src/spcc_ram.sv @@
module spcc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/spcc_sqrt.sv @@
module spcc_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [spcc_pkg::RAD_W-1:0]  radicand,
	output logic                      done,
	output logic [spcc_pkg::ROOT_W-1:0] root
);
	import spcc_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic              ge;

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= (ROOT_W+1)'(ge ? rem_sh - trial : rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

@@ src/spcc_div.sv @@
module spcc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [spcc_pkg::NUM_W-1:0] dividend,
	input  logic [spcc_pkg::DEN_W-1:0] divisor,
	output logic                      done,
	output logic [spcc_pkg::NUM_W-1:0] quotient
);
	import spcc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign ge       = rem_sh >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= DEN_W'(ge ? rem_sh - {1'b0, den_q} : rem_sh);
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

endmodule

@@ src/swept_path_collision_check.sv @@
// Swept-path collision check over a table of drones.
// The input channel (in_valid/in_stall) carries two kinds of transaction: a write
// (req_type 0) stores position, velocity and active flag in one table entry, and a
// query (req_type 1) brings a sample point. Each query yields one transaction on
// the output channel (out_valid/out_stall): state_valid is 1 when the point is clear.
// A write yields nothing. A query is handled alone: first the own drone's distance,
// speed and travel time are found, then each skipped entry is passed over and each
// other active drone is examined. Each examined drone uses the bit-serial square
// root once and the radix-2 divider at most once; the own drone's step uses the
// square root twice and the divider once.
// The scan stops at the first collision found.
// Reset clears the configuration to its defaults and all active flags; the table
// contents are undefined until written. A stalled result is held in the output
// register, and the next transaction is accepted while it waits; a finished query
// waits for that register to free before the block returns to accepting.
module swept_path_collision_check #(
	parameter int MAX_DRONES  = 16,
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [30:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [3:0]                    entry_index,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] vel_x,
	input  logic signed [COORD_WIDTH-1:0] vel_y,
	input  logic                          entry_active,
	input  logic signed [COORD_WIDTH-1:0] sample_x,
	input  logic signed [COORD_WIDTH-1:0] sample_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          state_valid
);
	import spcc_pkg::*;

	localparam int AW = $clog2(MAX_DRONES);
	localparam int CW = COORD_WIDTH;
	localparam int DW = 4 * CW;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_OWN_RD  = 14'b00000000000010,
		ST_OWN_MUL = 14'b00000000000100,
		ST_OWN_SQD = 14'b00000000001000,
		ST_OWN_SQS = 14'b00000000010000,
		ST_OWN_DIV = 14'b00000000100000,
		ST_SCAN    = 14'b00000001000000,
		ST_DR_LD   = 14'b00000010000000,
		ST_DR_MUL  = 14'b00000100000000,
		ST_DR_SQ   = 14'b00001000000000,
		ST_DR_MUL2 = 14'b00010000000000,
		ST_DR_DIV  = 14'b00100000000000,
		ST_FIN     = 14'b01000000000000,
		ST_SPARE   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [3:0]  own_index_q;
	logic [4:0]  drone_count_q;
	logic [30:0] clearance_q;
	logic [30:0] seg_tol_q;
	logic [30:0] min_speed_q;

	logic [MAX_DRONES-1:0] active_q;
	logic signed [CW-1:0]  sx_q, sy_q;
	logic signed [31:0]    ax_q, ay_q, wx_q, wy_q;
	logic [63:0]           sum_a_q, sum_b_q, clr2_q, len_q, lim_q;
	logic signed [63:0]    dot_q, cross_q, prod_q;
	logic [31:0]           d_q, t_q, vm_q;
	logic [4:0]            scan_q;
	logic [3:0]            step_q;
	logic                  result_q;
	logic                  out_valid_q;
	logic                  state_valid_q;

	logic                  in_fire;
	logic                  wr_ok;
	logic [AW-1:0]         own_idx;
	logic [AW-1:0]         scan_addr;
	logic [AW-1:0]         raddr;
	logic [4:0]            cnt_w;
	logic [DW-1:0]         rdata;
	logic signed [CW-1:0]  rd_px, rd_py, rd_vx, rd_vy;
	logic signed [CW:0]    dif_x, dif_y;
	logic signed [32:0]    mul_a, mul_b;
	logic signed [65:0]    prod_w;
	logic                  sq_start, sq_done;
	logic [RAD_W-1:0]      sq_rad;
	logic [ROOT_W-1:0]     sq_root;
	logic                  div_start, div_done;
	logic [NUM_W-1:0]      div_num, div_quo;
	logic [DEN_W-1:0]      div_den, s_w;
	logic [63:0]           dot_mag, cross_mag, umc, lhs, rhs;
	logic                  near, in_seg, hit_w;

	assign in_stall    = state_q != ST_IDLE;
	assign in_fire     = in_valid && (state_q == ST_IDLE);
	assign wr_ok       = in_fire && !req_type && (32'(entry_index) < MAX_DRONES);
	assign own_idx     = AW'(32'(own_index_q) % MAX_DRONES);
	assign cnt_w       = (32'(drone_count_q) > MAX_DRONES) ? 5'(MAX_DRONES) : drone_count_q;
	assign scan_addr   = AW'(scan_q);
	assign raddr       = (state_q == ST_SCAN) ? scan_addr : own_idx;
	assign out_valid   = out_valid_q;
	assign state_valid = state_valid_q;

	spcc_ram #(.WIDTH(DW), .DEPTH(MAX_DRONES)) u_table (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (AW'(entry_index)),
		.wdata ({pos_x, pos_y, vel_x, vel_y}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_px = rdata[DW-1 -: CW];
	assign rd_py = rdata[3*CW-1 -: CW];
	assign rd_vx = rdata[2*CW-1 -: CW];
	assign rd_vy = rdata[CW-1:0];
	assign dif_x = (CW+1)'(sx_q) - (CW+1)'(rd_px);
	assign dif_y = (CW+1)'(sy_q) - (CW+1)'(rd_py);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_OWN_MUL) begin
			case (step_q)
				4'd0: begin mul_a = 33'(ax_q); mul_b = 33'(ax_q); end
				4'd1: begin mul_a = 33'(ay_q); mul_b = 33'(ay_q); end
				4'd2: begin mul_a = 33'(wx_q); mul_b = 33'(wx_q); end
				4'd3: begin mul_a = 33'(wy_q); mul_b = 33'(wy_q); end
				4'd4: begin
					mul_a = $signed({2'b00, clearance_q});
					mul_b = $signed({2'b00, clearance_q});
				end
				default: ;
			endcase
		end else if (state_q == ST_DR_MUL) begin
			case (step_q)
				4'd0: begin mul_a = 33'(ax_q); mul_b = 33'(ax_q); end
				4'd1: begin mul_a = 33'(ay_q); mul_b = 33'(ay_q); end
				4'd2: begin mul_a = 33'(wx_q); mul_b = 33'(wx_q); end
				4'd3: begin mul_a = 33'(wy_q); mul_b = 33'(wy_q); end
				4'd4: begin mul_a = 33'(ax_q); mul_b = 33'(wx_q); end
				4'd5: begin mul_a = 33'(ay_q); mul_b = 33'(wy_q); end
				4'd6: begin mul_a = 33'(ax_q); mul_b = 33'(wy_q); end
				4'd7: begin mul_a = 33'(ay_q); mul_b = 33'(wx_q); end
				default: ;
			endcase
		end else if (state_q == ST_DR_MUL2) begin
			case (step_q)
				4'd0: begin mul_a = $signed({1'b0, vm_q}); mul_b = $signed({1'b0, t_q}); end
				4'd1: begin
					mul_a = $signed({2'b00, clearance_q});
					mul_b = $signed({1'b0, vm_q});
				end
				default: ;
			endcase
		end
	end

	assign prod_w = mul_a * mul_b;

	assign sq_start = ((state_q == ST_OWN_MUL) && (step_q == 4'd5))
		|| ((state_q == ST_OWN_SQD) && sq_done)
		|| ((state_q == ST_DR_MUL) && (step_q == 4'd8));
	assign sq_rad = (state_q == ST_OWN_MUL) ? sum_a_q : sum_b_q;

	spcc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign s_w = (sq_root != '0) ? sq_root
		: ((min_speed_q != '0) ? DEN_W'(min_speed_q) : DEN_W'(1));
	assign dot_mag   = $unsigned(dot_q[63] ? -dot_q : dot_q);
	assign cross_mag = $unsigned(cross_q[63] ? -cross_q : cross_q);

	assign div_start = ((state_q == ST_OWN_SQS) && sq_done)
		|| ((state_q == ST_DR_MUL2) && (step_q == 4'd2));
	assign div_num = (state_q == ST_OWN_SQS) ? (NUM_W'(d_q) << FRAC_BITS) : dot_mag;
	assign div_den = (state_q == ST_OWN_SQS) ? s_w : vm_q;

	spcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign near   = sum_a_q < clr2_q;
	assign umc    = (div_quo > U_CAP) ? U_CAP : div_quo;
	assign lhs    = {umc[62:0], 1'b0};
	assign rhs    = dot_q[63] ? 64'(seg_tol_q) : ({len_q[62:0], 1'b0} + 64'(seg_tol_q));
	assign in_seg = lhs <= rhs;
	assign hit_w  = in_seg ? (cross_mag < lim_q) : near;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_index_q   <= 4'd0;
			drone_count_q <= 5'd16;
			clearance_q   <= 31'd19661;
			seg_tol_q     <= 31'd655;
			min_speed_q   <= 31'd6554;
			active_q      <= '0;
			scan_q        <= '0;
			step_q        <= '0;
			result_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			state_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OWN_INDEX:   own_index_q   <= cfg_data[3:0];
					CFG_DRONE_COUNT: drone_count_q <= cfg_data[4:0];
					CFG_CLEARANCE:   clearance_q   <= cfg_data;
					CFG_SEG_TOL:     seg_tol_q     <= cfg_data;
					CFG_MIN_SPEED:   min_speed_q   <= cfg_data;
					default: ;
				endcase
			end
			if (wr_ok) begin
				active_q[AW'(entry_index)] <= entry_active;
			end
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && req_type) begin
						state_q <= ST_OWN_RD;
					end
				end
				ST_OWN_RD: begin
					state_q <= ST_OWN_MUL;
					step_q  <= '0;
				end
				ST_OWN_MUL: begin
					if (step_q == 4'd5) begin
						state_q <= ST_OWN_SQD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OWN_SQD: begin
					if (sq_done) begin
						state_q <= ST_OWN_SQS;
					end
				end
				ST_OWN_SQS: begin
					if (sq_done) begin
						state_q <= ST_OWN_DIV;
					end
				end
				ST_OWN_DIV: begin
					if (div_done) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_q >= cnt_w) begin
						result_q <= 1'b1;
						state_q  <= ST_FIN;
					end else if ((scan_addr == own_idx) || !active_q[scan_addr]) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= ST_DR_LD;
					end
				end
				ST_DR_LD: begin
					state_q <= ST_DR_MUL;
					step_q  <= '0;
				end
				ST_DR_MUL: begin
					if (step_q == 4'd8) begin
						state_q <= ST_DR_SQ;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DR_SQ: begin
					if (sq_done) begin
						if ((sq_root == '0) || (t_q == '0)) begin
							if (near) begin
								result_q <= 1'b0;
								state_q  <= ST_FIN;
							end else begin
								scan_q  <= scan_q + 1'b1;
								state_q <= ST_SCAN;
							end
						end else begin
							state_q <= ST_DR_MUL2;
							step_q  <= '0;
						end
					end
				end
				ST_DR_MUL2: begin
					if (step_q == 4'd2) begin
						state_q <= ST_DR_DIV;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DR_DIV: begin
					if (div_done) begin
						if (hit_w) begin
							result_q <= 1'b0;
							state_q  <= ST_FIN;
						end else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						state_valid_q <= result_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_w[63:0];
		if (in_fire) begin
			sx_q <= sample_x;
			sy_q <= sample_y;
		end
		if ((state_q == ST_OWN_RD) || (state_q == ST_DR_LD)) begin
			ax_q <= sat_val(64'(dif_x));
			ay_q <= sat_val(64'(dif_y));
			wx_q <= sat_val(64'(rd_vx));
			wy_q <= sat_val(64'(rd_vy));
		end
		if (state_q == ST_OWN_MUL) begin
			case (step_q)
				4'd1: sum_a_q <= $unsigned(prod_q);
				4'd2: sum_a_q <= sum_a_q + $unsigned(prod_q);
				4'd3: sum_b_q <= $unsigned(prod_q);
				4'd4: sum_b_q <= sum_b_q + $unsigned(prod_q);
				4'd5: clr2_q  <= $unsigned(prod_q);
				default: ;
			endcase
		end
		if (state_q == ST_DR_MUL) begin
			case (step_q)
				4'd1: sum_a_q <= $unsigned(prod_q);
				4'd2: sum_a_q <= sum_a_q + $unsigned(prod_q);
				4'd3: sum_b_q <= $unsigned(prod_q);
				4'd4: sum_b_q <= sum_b_q + $unsigned(prod_q);
				4'd5: dot_q   <= prod_q;
				4'd6: dot_q   <= dot_q + prod_q;
				4'd7: cross_q <= prod_q;
				4'd8: cross_q <= cross_q - prod_q;
				default: ;
			endcase
		end
		if (state_q == ST_DR_MUL2) begin
			case (step_q)
				4'd1: len_q <= $unsigned(prod_q) >> FRAC_BITS;
				4'd2: lim_q <= $unsigned(prod_q);
				default: ;
			endcase
		end
		if ((state_q == ST_OWN_SQD) && sq_done) begin
			d_q <= sq_root;
		end
		if ((state_q == ST_OWN_DIV) && div_done) begin
			t_q <= (div_quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_quo[31:0];
		end
		if ((state_q == ST_DR_SQ) && sq_done) begin
			vm_q <= sq_root;
		end
	end

endmodule

@@ src/spcc_checker.sv @@
`include "swept_path_collision_check_defines.svh"

module spcc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic req_type,
	input logic out_valid,
	input logic out_stall,
	input logic state_valid
);

	`SPCC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`SPCC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(state_valid))
	`SPCC_ASSERT_NEXT(a_write_no_result, clk, arst_n, in_valid && !in_stall && !req_type && !out_valid, !out_valid)
	`SPCC_ASSERT_SAME(a_query_busy, clk, arst_n, $past(in_valid && !in_stall && req_type), in_stall)

endmodule

bind swept_path_collision_check spcc_checker u_spcc_checker (.*);
